### sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define DPB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deband blend check failed");

// clocked check that also runs during reset
`define DPB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("deband blend check failed");

`endif

### sv/dpb_pkg.sv
// package: widths, register map and shared types of the deband pixel blend
package dpb_pkg;

    localparam int PIX_W  = 8;
    localparam int MODE_W = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [1:0] REG_REF_MODE     = 2'd1;
    localparam logic [1:0] REG_BLUR_COMPARE = 2'd2;

    // sample modes
    localparam logic [MODE_W-1:0] MODE_FOUR = 2'd2;

    // reset values
    localparam logic [PIX_W-1:0]  THRESHOLD_RST    = 8'd0;
    localparam logic [MODE_W-1:0] REF_MODE_RST     = 2'd2;
    localparam logic              BLUR_COMPARE_RST = 1'b1;

    // sign bit of the dither
    localparam logic [PIX_W-1:0] SIGN_BIAS = 8'h80;

    typedef struct packed {
        logic [PIX_W-1:0]  threshold;
        logic [MODE_W-1:0] ref_mode;
        logic              blur_compare;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] source_pixel;
        logic [PIX_W-1:0] ref_a;
        logic [PIX_W-1:0] ref_b;
        logic [PIX_W-1:0] ref_c;
        logic [PIX_W-1:0] ref_d;
        logic [PIX_W-1:0] dither;
    } pix_word_t;

endpackage

### sv/dpb_regs.sv
// configuration register file behind the apb port
module dpb_regs
    import dpb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= THRESHOLD_RST;
            cfg_reg.ref_mode     <= REF_MODE_RST;
            cfg_reg.blur_compare <= BLUR_COMPARE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_THRESHOLD:    cfg_reg.threshold    <= pwdata[PIX_W-1:0];
                REG_REF_MODE:     cfg_reg.ref_mode     <= pwdata[MODE_W-1:0];
                REG_BLUR_COMPARE: cfg_reg.blur_compare <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THRESHOLD:    prdata = {{(DATA_W-PIX_W){1'b0}}, cfg_reg.threshold};
            REG_REF_MODE:     prdata = {{(DATA_W-MODE_W){1'b0}}, cfg_reg.ref_mode};
            REG_BLUR_COMPARE: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.blur_compare};
            default:          prdata = '0;
        endcase
    end

endmodule

### sv/dpb_blend.sv
// blur, threshold test and saturating dither add for one pixel
module dpb_blend
    import dpb_pkg::*;
(
    input  cfg_t             cfg,
    input  pix_word_t        word,
    output logic [PIX_W-1:0] result_pixel
);

    logic             four;
    logic [PIX_W:0]   sum_ab;
    logic [PIX_W:0]   sum_cd;
    logic [PIX_W-1:0] avg_ab;
    logic [PIX_W-1:0] avg_cd;
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi_dec;
    logic [PIX_W:0]   sum_mix;
    logic [PIX_W-1:0] blur;
    logic             keep_blur;
    logic             keep_refs;
    logic             keep;
    logic [PIX_W-1:0] chosen;
    logic [PIX_W+1:0] dsum;

    // absolute difference at or above threshold
    function automatic logic over_limit(input logic [PIX_W-1:0] a,
                                        input logic [PIX_W-1:0] b,
                                        input logic [PIX_W-1:0] thr);
        logic [PIX_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d >= thr;
    endfunction

    assign four = (cfg.ref_mode == MODE_FOUR);

    always_comb
    begin
        sum_ab  = {1'b0, word.ref_a} + {1'b0, word.ref_b} + 9'd1;
        sum_cd  = {1'b0, word.ref_c} + {1'b0, word.ref_d} + 9'd1;
        avg_ab  = sum_ab[PIX_W:1];
        avg_cd  = sum_cd[PIX_W:1];
        hi      = (avg_ab > avg_cd) ? avg_ab : avg_cd;
        lo      = (avg_ab > avg_cd) ? avg_cd : avg_ab;
        hi_dec  = (hi != '0) ? hi - 8'd1 : '0;
        sum_mix = {1'b0, hi_dec} + {1'b0, lo} + 9'd1;
        blur    = four ? sum_mix[PIX_W:1] : avg_ab;

        keep_blur = over_limit(word.source_pixel, blur, cfg.threshold);
        keep_refs = over_limit(word.source_pixel, word.ref_a, cfg.threshold)
                 || over_limit(word.source_pixel, word.ref_b, cfg.threshold)
                 || (four && (over_limit(word.source_pixel, word.ref_c, cfg.threshold)
                           || over_limit(word.source_pixel, word.ref_d, cfg.threshold)));
        keep   = cfg.blur_compare ? keep_blur : keep_refs;
        chosen = keep ? word.source_pixel : blur;

        // 10-bit signed sum of pixel and sign-extended dither
        dsum = {2'b00, chosen}
             + {{2{(word.dither & SIGN_BIAS) != '0}}, word.dither};
        if (dsum[PIX_W+1])
            result_pixel = '0;
        else if (dsum[PIX_W])
            result_pixel = '1;
        else
            result_pixel = dsum[PIX_W-1:0];
    end

endmodule

### sv/deband_pixel_blend.sv
// top level of the deband pixel blend: input register, blend logic, result register
// deband pixel blend core. one input word (source pixel, four reference
// pixels, signed dither) gives one result word (the debanded pixel). a word
// can be accepted every cycle while out_stall is low: throughput is then one
// word per clock. out_valid rises once the word has passed the input register
// and the result register that bracket the blend logic. the blur is the rounded
// average of ref_a and ref_b, or in four-reference mode the average of the
// two pair averages with the larger one lowered by one. the source pixel is
// kept when it is at least threshold away from the blur (blur_compare set) or
// from any used reference; the dither is then added with clamping to 0..255.
// configuration sits behind an apb port at byte addresses 0 (threshold),
// 4 (ref_mode) and 8 (blur_compare) and must only be written while idle.
`include "assert_macros.svh"

module deband_pixel_blend_core
    import dpb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    // apb configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    // input word channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [PIX_W-1:0]  source_pixel,
    input  logic [PIX_W-1:0]  ref_a,
    input  logic [PIX_W-1:0]  ref_b,
    input  logic [PIX_W-1:0]  ref_c,
    input  logic [PIX_W-1:0]  ref_d,
    input  logic signed [PIX_W-1:0] dither,

    // result word channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [PIX_W-1:0]  result_pixel
);

    cfg_t             cfg;
    pix_word_t        in_word_reg;
    logic             in_valid_reg;
    logic [PIX_W-1:0] blend_pixel;
    logic [PIX_W-1:0] result_reg;
    logic             out_valid_reg;
    logic             out_ready;
    logic             in_ready;
    logic             in_take;

    dpb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // result register is free when empty or being drained this cycle
    assign out_ready = !out_valid_reg || !out_stall;
    // input register is free when empty or moving into the result register
    assign in_ready  = !in_valid_reg || out_ready;
    assign in_stall  = !in_ready;
    assign in_take   = in_valid && in_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg.source_pixel <= source_pixel;
            in_word_reg.ref_a        <= ref_a;
            in_word_reg.ref_b        <= ref_b;
            in_word_reg.ref_c        <= ref_c;
            in_word_reg.ref_d        <= ref_d;
            in_word_reg.dither       <= dither;
        end
    end

    // blend logic between the two registers
    dpb_blend u_blend (
        .cfg          (cfg),
        .word         (in_word_reg),
        .result_pixel (blend_pixel)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && in_valid_reg)
            result_reg <= blend_pixel;
    end

    assign out_valid    = out_valid_reg;
    assign result_pixel = result_reg;

    // a full pipe with a stalled output must hold off new words
    `DPB_ASSERT(a_full_stalls, (in_valid_reg && out_valid_reg && out_stall) |-> in_stall)
    // an accepted word lands in the input register
    `DPB_ASSERT(a_take_loads, in_take |=> in_valid_reg)
    // a word leaving the input register shows up as a result
    `DPB_ASSERT(a_move_shows, (in_valid_reg && out_ready) |=> out_valid)
    // a threshold write is visible in the next cycle
    `DPB_ASSERT(a_thr_write, (psel && penable && pwrite && paddr[3:2] == REG_THRESHOLD)
        |=> cfg.threshold == $past(pwdata[PIX_W-1:0]))

endmodule

### test/testbench.sv
// testbench of the deband pixel blend core: random and directed words against a predictor
`timescale 1ns / 1ps

module testbench;
    import dpb_pkg::*;

    // register index with no register behind it, writes there must be dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int RANDOM_PHASES    = 12;
    localparam int WORDS_PER_PHASE  = 150;
    localparam int MAX_WAIT         = 9;
    localparam int END_LATENCY      = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // apb configuration port
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // input word channel
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [PIX_W-1:0]        source_pixel = '0;
    logic [PIX_W-1:0]        ref_a = '0;
    logic [PIX_W-1:0]        ref_b = '0;
    logic [PIX_W-1:0]        ref_c = '0;
    logic [PIX_W-1:0]        ref_d = '0;
    logic signed [PIX_W-1:0] dither = '0;

    // result word channel
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [PIX_W-1:0] result_pixel;

    // words waiting to be sent, and debanded pixels waiting to come out
    pix_word_t        pixel_queue[$];
    logic [PIX_W-1:0] expected_pixels[$];

    // copy of the configuration registers as the block should hold them
    cfg_t shadow_cfg = '{threshold: THRESHOLD_RST, ref_mode: REF_MODE_RST,
                         blur_compare: BLUR_COMPARE_RST};

    int  fail_count = 0;
    int  words_queued = 0;
    int  words_checked = 0;
    int  in_gap_max = MAX_WAIT;
    int  out_gap_max = MAX_WAIT;
    int  in_wait = 0;
    int  out_wait = 0;
    // handshake outcome of the last rising edge, used by the falling-edge drivers
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;

    deband_pixel_blend_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .source_pixel (source_pixel),
        .ref_a        (ref_a),
        .ref_b        (ref_b),
        .ref_c        (ref_c),
        .ref_d        (ref_d),
        .dither       (dither),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_pixel (result_pixel)
    );

    always #5 clk = ~clk;

    // true when two pixels are at least the threshold apart
    function automatic logic far_apart(input int a, input int b, input int limit);
        int diff;
        diff = (a > b) ? a - b : b - a;
        return diff >= limit;
    endfunction

    // debanded pixel for one input word under the given register settings
    function automatic logic [PIX_W-1:0] blend_pixel(input cfg_t c, input pix_word_t w);
        int   src, ra, rb, rc, rd, thr;
        int   avg_cd, hi, lo, blur, total;
        logic four, keep;
        src = w.source_pixel;
        ra = w.ref_a;
        rb = w.ref_b;
        rc = w.ref_c;
        rd = w.ref_d;
        thr = c.threshold;
        // modes 0 and 3 fall back to the two-reference blur
        four = (c.ref_mode == MODE_FOUR);
        blur = (ra + rb + 1) >> 1;
        if (four)
        begin
            avg_cd = (rc + rd + 1) >> 1;
            hi = (blur > avg_cd) ? blur : avg_cd;
            lo = (blur > avg_cd) ? avg_cd : blur;
            // larger pair average lowered by one, never below zero
            if (hi > 0)
                hi = hi - 1;
            blur = (hi + lo + 1) >> 1;
        end
        if (c.blur_compare)
            keep = far_apart(src, blur, thr);
        else
        begin
            keep = far_apart(src, ra, thr) || far_apart(src, rb, thr);
            if (four)
                keep = keep || far_apart(src, rc, thr) || far_apart(src, rd, thr);
        end
        // signed dither added with clamping to the pixel range
        total = (keep ? src : blur) + int'($signed(w.dither));
        if (total < 0)
            total = 0;
        if (total > 255)
            total = 255;
        return total[PIX_W-1:0];
    endfunction

    // reference pixel within spread of the source, clamped to the pixel range
    function automatic logic [PIX_W-1:0] near_pixel(input int src, input int spread);
        int p;
        p = src + $urandom_range(0, 2 * spread) - spread;
        if (p < 0)
            p = 0;
        if (p > 255)
            p = 255;
        return p[PIX_W-1:0];
    endfunction

    // input driver: one word at a time, with a random gap after each word
    always @(negedge clk)
    begin : drive_words
        pix_word_t w;
        if (rst_n)
        begin
            // a stalled word stays on the bus untouched
            if (!in_valid || in_taken)
            begin
                if (in_wait > 0)
                begin
                    in_wait = in_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (pixel_queue.size() != 0)
                begin
                    w = pixel_queue.pop_front();
                    source_pixel <= w.source_pixel;
                    ref_a <= w.ref_a;
                    ref_b <= w.ref_b;
                    ref_c <= w.ref_c;
                    ref_d <= w.ref_d;
                    dither <= w.dither;
                    in_valid <= 1'b1;
                    in_wait = $urandom_range(0, in_gap_max);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result side back pressure: a random number of stall cycles per word
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                out_wait = $urandom_range(0, out_gap_max);
            if (out_wait > 0)
            begin
                out_wait = out_wait - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor: predict each accepted input word and check each accepted result word
    always @(posedge clk)
    begin : watch_words
        logic [PIX_W-1:0] want;
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
            expected_pixels.push_back(blend_pixel(shadow_cfg,
                {source_pixel, ref_a, ref_b, ref_c, ref_d, dither}));
        out_taken = rst_n && out_valid && !out_stall;
        if (out_taken)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: result word with none pending, expected nothing, actual %0d",
                         $time, result_pixel);
                fail_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                words_checked++;
                if (result_pixel !== want)
                begin
                    $display("%0t: result_pixel mismatch, expected %0d, actual %0d",
                             $time, want, result_pixel);
                    fail_count++;
                end
            end
        end
    end

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // registers keep only their own width, other indexes are dropped
        case (idx)
            REG_THRESHOLD:    shadow_cfg.threshold = value[PIX_W-1:0];
            REG_REF_MODE:     shadow_cfg.ref_mode = value[MODE_W-1:0];
            REG_BLUR_COMPARE: shadow_cfg.blur_compare = value[0];
            default:          ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic queue_word(input int src, input int ra, input int rb, input int rc,
                              input int rd, input int dith);
        pix_word_t w;
        w.source_pixel = src[PIX_W-1:0];
        w.ref_a = ra[PIX_W-1:0];
        w.ref_b = rb[PIX_W-1:0];
        w.ref_c = rc[PIX_W-1:0];
        w.ref_d = rd[PIX_W-1:0];
        w.dither = dith[PIX_W-1:0];
        pixel_queue.push_back(w);
        words_queued++;
    endtask

    // hold the sender until every queued word has come back checked
    task automatic wait_for_results();
        while (words_checked != words_queued)
            @(negedge clk);
    endtask

    // random register settings, with junk in the upper bits of each write
    task automatic random_config();
        int thr;
        case ($urandom_range(0, 3))
            0:       thr = 0;
            1:       thr = 255;
            2:       thr = $urandom_range(1, 32);
            default: thr = $urandom_range(0, 255);
        endcase
        write_reg(REG_THRESHOLD, ($urandom() & 32'hFFFF_FF00) | thr);
        write_reg(REG_REF_MODE, ($urandom() & 32'hFFFF_FFFC) | $urandom_range(0, 3));
        write_reg(REG_BLUR_COMPARE, ($urandom() & 32'hFFFF_FFFE) | $urandom_range(0, 1));
    endtask

    task automatic random_words(input int count);
        int src, spread;
        for (int i = 0; i < count; i++)
        begin
            src = $urandom_range(0, 255);
            if ($urandom_range(0, 1))
                queue_word(src, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
            else
            begin
                // references close to the source so the threshold test goes both ways
                spread = $urandom_range(1, 40);
                queue_word(src, near_pixel(src, spread), near_pixel(src, spread),
                           near_pixel(src, spread), near_pixel(src, spread),
                           ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255));
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: zero threshold keeps every source, only dither applies
        queue_word(0, 0, 0, 0, 0, -128);
        queue_word(255, 255, 255, 255, 255, 127);
        queue_word(8'h5A, 0, 255, 0, 255, 0);
        wait_for_results();

        // top threshold written with all bits set, four references, blur compare
        write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
        queue_word(0, 255, 255, 255, 255, 0);
        queue_word(128, 0, 0, 0, 0, 5);
        queue_word(128, 0, 1, 0, 0, -1);
        queue_word(100, 10, 20, 200, 250, -128);
        queue_word(200, 255, 0, 1, 0, 127);
        wait_for_results();

        // two references, compare against each: ref_c and ref_d must not matter
        write_reg(REG_THRESHOLD, 16);
        write_reg(REG_REF_MODE, 1);
        write_reg(REG_BLUR_COMPARE, 0);
        queue_word(100, 100, 100, 0, 255, 0);
        queue_word(100, 116, 100, 0, 0, 0);
        queue_word(100, 115, 85, 0, 0, 0);
        queue_word(50, 50, 50, 255, 255, -3);
        wait_for_results();

        // unused mode 0 acts as two references; a write past the map is dropped
        write_reg(REG_REF_MODE, 0);
        write_reg(REG_BLUR_COMPARE, 1);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        queue_word(40, 60, 70, 0, 0, 0);
        queue_word(40, 41, 39, 200, 200, 1);
        wait_for_results();

        // unused mode 3, smallest nonzero threshold
        write_reg(REG_REF_MODE, 3);
        write_reg(REG_BLUR_COMPARE, 0);
        write_reg(REG_THRESHOLD, 1);
        queue_word(9, 9, 9, 250, 250, 0);
        queue_word(9, 10, 9, 0, 0, 0);
        wait_for_results();

        // four references compared one by one
        write_reg(REG_REF_MODE, MODE_FOUR);
        write_reg(REG_THRESHOLD, 40);
        queue_word(128, 128, 128, 168, 128, 0);
        queue_word(128, 128, 128, 167, 89, 10);
        queue_word(255, 255, 255, 255, 255, 127);
        wait_for_results();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_config();
            // every fourth phase runs back to back with no idling on either side
            in_gap_max = (phase % 4 == 0) ? 0 : MAX_WAIT;
            out_gap_max = (phase % 4 == 0) ? 0 : MAX_WAIT;
            if (phase == RANDOM_PHASES / 2)
            begin
                // sender holds off mid-phase until the pipeline has emptied
                random_words(WORDS_PER_PHASE / 2);
                wait_for_results();
                random_words(WORDS_PER_PHASE - WORDS_PER_PHASE / 2);
            end
            else
                random_words(WORDS_PER_PHASE);
            wait_for_results();
        end

        repeat (END_LATENCY) @(posedge clk);
        fail_count += expected_pixels.size();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/dpb_pkg.sv
sv/dpb_regs.sv
sv/dpb_blend.sv
sv/deband_pixel_blend.sv
test/testbench.sv
